// ----- design/date_age_calculator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the date age calculator
// Short forms for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DATE_AGE_CALCULATOR_TOP_ASSERT_SVH
`define DATE_AGE_CALCULATOR_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define DAC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define DAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/dac_pkg.sv -----
// ----------------------------------------------------------------------------
// dac_pkg
// Types, status codes and calendar helpers for the date age calculator.
// ----------------------------------------------------------------------------
package dac_pkg;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_ORDER   = 2'd2
	} status_t;

	typedef struct packed {
		logic [11:0] start_year;
		logic [3:0]  start_month;
		logic [5:0]  start_day;
		logic [11:0] end_year;
		logic [3:0]  end_month;
		logic [5:0]  end_day;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [13:0] age_months;
		logic [15:0] age_weeks;
		logic [18:0] age_days;
	} rsp_t;

	localparam int unsigned YEAR_MIN = 1900;
	localparam int unsigned YEAR_MAX = 3000;
	localparam int unsigned DAYS_PER_YEAR = 365;

	// x / 100 = (x * 5243) >> 19, exact for 12-bit x
	localparam int unsigned DIV100_MUL   = 5243;
	localparam int unsigned DIV100_SHIFT = 19;
	// x / 30 = (x * 559241) >> 24, exact for 20-bit x
	localparam int unsigned DIV30_MUL    = 559241;
	localparam int unsigned DIV30_SHIFT  = 24;
	// x / 7 = (x * 599187) >> 22, exact for x below 2^19 + 2^18
	localparam int unsigned DIV7_MUL     = 599187;
	localparam int unsigned DIV7_SHIFT   = 22;

	function automatic logic [5:0] div100(input logic [11:0] v);
		logic [24:0] prod;
		prod = 25'(v) * 25'(DIV100_MUL);
		return prod[DIV100_SHIFT +: 6];
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        len = 5'd31;
			default:                   len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the year before the first of month m (non-leap)
	function automatic logic [8:0] month_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- design/date_age_calculator_top.sv -----
// Four register stages lie between request accept and result valid.
// Throughput: one request per cycle; each of the four stages holds when the
// stage after it is full and not advancing, so a stalled result blocks nothing
// upstream until the pipeline is full.
// Reset: arst_n clears all stage valid bits at once; no result is pending after it.
// ----------------------------------------------------------------------------
// date_age_calculator_top
// Checks two Gregorian dates and returns the day difference with weeks and 30-day months rounded up.
// ----------------------------------------------------------------------------
`include "date_age_calculator_top_assert.svh"

module date_age_calculator_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dac_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dac_pkg::rsp_t  rsp
);

	typedef struct packed {
		logic        year_ok;
		logic        month_ok;
		logic        leap;
		logic [3:0]  month;
		logic [5:0]  day;
		logic [11:0] prev_year;
		logic [5:0]  prev_cent;
	} date_dec_t;

	// stage enables, back to front
	logic en1, en2, en3, en4;
	logic v1_s1, v2_s2, v3_s3, v4_s4;

	date_dec_t        dec_c [2];
	date_dec_t        dec_s1 [2];
	logic             ok_c [2];
	logic [20:0]      dn_c [2];

	logic             ok_s2;
	logic [20:0]      a_s2, b_s2;

	dac_pkg::status_t status_c, status_s3;
	logic [18:0]      diff_c, diff_s3;

	logic [19:0]      num30_c, num7_c;
	logic [43:0]      prod30_c;
	logic [39:0]      prod7_c;
	dac_pkg::rsp_t    rsp_s4;

	assign en4       = !v4_s4 || rsp_ready;
	assign en3       = !v3_s3 || en4;
	assign en2       = !v2_s2 || en3;
	assign en1       = !v1_s1 || en2;
	assign req_ready = en1;
	assign rsp_valid = v4_s4;
	assign rsp       = rsp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= req_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	// ---- stage 1: range checks, leap year, year split for the day count
	always_comb begin
		logic [11:0] y [2];
		logic [3:0]  m [2];
		logic [5:0]  d [2];
		logic [5:0]  cent;
		logic [11:0] rem100;
		y[0] = req.start_year;  m[0] = req.start_month;  d[0] = req.start_day;
		y[1] = req.end_year;    m[1] = req.end_month;    d[1] = req.end_day;
		for (int i = 0; i < 2; i++) begin
			cent   = dac_pkg::div100(y[i]);
			rem100 = y[i] - 12'(cent) * 12'd100;
			dec_c[i].year_ok   = y[i] inside {[dac_pkg::YEAR_MIN:dac_pkg::YEAR_MAX]};
			dec_c[i].month_ok  = m[i] inside {[4'd1:4'd12]};
			// divisible by 400 is a whole century whose count is a multiple of 4
			dec_c[i].leap      = (y[i][1:0] == 2'd0 && rem100 != 12'd0) ||
				(rem100 == 12'd0 && cent[1:0] == 2'd0);
			dec_c[i].month     = m[i];
			dec_c[i].day       = d[i];
			dec_c[i].prev_year = y[i] - 12'd1;
			dec_c[i].prev_cent = dac_pkg::div100(y[i] - 12'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			dec_s1 <= dec_c;
		end
	end

	// ---- stage 2: day check and day number
	always_comb begin
		logic [4:0] len;
		for (int i = 0; i < 2; i++) begin
			len      = dac_pkg::month_len(dec_s1[i].month, dec_s1[i].leap);
			ok_c[i]  = dec_s1[i].year_ok && dec_s1[i].month_ok &&
				dec_s1[i].day != 6'd0 && dec_s1[i].day <= 6'(len);
			dn_c[i]  = 21'(dec_s1[i].prev_year) * 21'(dac_pkg::DAYS_PER_YEAR)
				+ 21'(dec_s1[i].prev_year[11:2])
				- 21'(dec_s1[i].prev_cent)
				+ 21'(dec_s1[i].prev_cent[5:2])
				+ 21'(dac_pkg::month_before(dec_s1[i].month))
				+ 21'(dec_s1[i].month > 4'd2 && dec_s1[i].leap)
				+ 21'(dec_s1[i].day);
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			ok_s2 <= ok_c[0] && ok_c[1];
			a_s2  <= dn_c[0];
			b_s2  <= dn_c[1];
		end
	end

	// ---- stage 3: ordering and difference
	always_comb begin
		status_c = dac_pkg::STATUS_OK;
		diff_c   = '0;
		if (!ok_s2) begin
			status_c = dac_pkg::STATUS_INVALID;
		end else if (b_s2 <= a_s2) begin
			status_c = dac_pkg::STATUS_ORDER;
		end else begin
			diff_c = 19'(b_s2 - a_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v2_s2) begin
			status_s3 <= status_c;
			diff_s3   <= diff_c;
		end
	end

	// ---- stage 4: ceiling divides by reciprocal multiply; zero diff gives zero
	assign num30_c  = 20'(diff_s3) + 20'd29;
	assign num7_c   = 20'(diff_s3) + 20'd6;
	assign prod30_c = 44'(num30_c) * 44'(dac_pkg::DIV30_MUL);
	assign prod7_c  = 40'(num7_c) * 40'(dac_pkg::DIV7_MUL);

	always_ff @(posedge clk) begin
		if (en4 && v3_s3) begin
			rsp_s4.status     <= status_s3;
			rsp_s4.age_months <= prod30_c[dac_pkg::DIV30_SHIFT +: 14];
			rsp_s4.age_weeks  <= prod7_c[dac_pkg::DIV7_SHIFT +: 16];
			rsp_s4.age_days   <= diff_s3;
		end
	end

	// ---- checks
	`DAC_ASSERT_SAME(a_zero_unless_ok, rsp_valid && rsp.status != dac_pkg::STATUS_OK, rsp.age_days == 19'd0 && rsp.age_weeks == 16'd0 && rsp.age_months == 14'd0, "nonzero age on failed request")
	`DAC_ASSERT_SAME(a_ok_positive, rsp_valid && rsp.status == dac_pkg::STATUS_OK, rsp.age_days != 19'd0 && rsp.age_weeks != 16'd0 && rsp.age_months != 14'd0, "ok result with zero age")
	`DAC_ASSERT_SAME(a_weeks_ge_months, rsp_valid && rsp.status == dac_pkg::STATUS_OK, 17'(rsp.age_weeks) >= 17'(rsp.age_months), "weeks below months")
	`DAC_ASSERT_NEXT(a_s3_holds, v3_s3 && !en4, v3_s3 && $stable(diff_s3) && $stable(status_s3), "stage 3 changed while stalled")

endmodule

// ----- dv/date_age_calculator_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_age_calculator_top_test
// Drives date pairs through the calculator with bursty requests and a
// stalling receiver. Each result is checked against a calendar predictor.
// The directed pairs cover calendar edges and the random pairs are mostly
// valid dates.
// ----------------------------------------------------------------------------
module date_age_calculator_top_test;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_REQS = 1750;
	localparam int unsigned DRAIN_WAIT  = 8;

	typedef struct packed {
		bit            drain;    // hold this request until nothing is outstanding
		dac_pkg::req_t payload;
	} queued_req_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	dac_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	dac_pkg::rsp_t rsp;

	queued_req_t   req_backlog[$];
	dac_pkg::rsp_t expected_rsp[$];

	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned ok_count = 0;
	int unsigned invalid_count = 0;
	int unsigned order_count = 0;
	int unsigned drains = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	logic [15:0] stall_pattern = 16'hffff;
	int unsigned pattern_age = 0;

	date_age_calculator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// calendar predictor
	// ------------------------------------------------------------------
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		case (m)
			2:             return leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   return 30;
			1, 3, 5, 7, 8,
			10, 12:        return 31;
			default:       return 0;
		endcase
	endfunction

	function automatic bit date_valid(input int unsigned y, input int unsigned m,
			input int unsigned d);
		if (y < dac_pkg::YEAR_MIN || y > dac_pkg::YEAR_MAX)
			return 1'b0;
		return (d >= 1) && (d <= month_days(y, m));
	endfunction

	// days since a fixed epoch, including the leap day of the year itself
	function automatic int unsigned day_serial(input int unsigned y, input int unsigned m,
			input int unsigned d);
		int unsigned p;
		int unsigned n;
		int unsigned mm;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400;
		for (mm = 1; mm < m; mm++)
			n += month_days(y, mm);
		return n + d;
	endfunction

	function automatic dac_pkg::rsp_t predict_age(input dac_pkg::req_t r);
		dac_pkg::rsp_t res;
		int unsigned   a;
		int unsigned   b;
		int unsigned   diff;
		res = '0;
		res.status = dac_pkg::STATUS_OK;
		if (!date_valid(r.start_year, r.start_month, r.start_day) ||
				!date_valid(r.end_year, r.end_month, r.end_day)) begin
			res.status = dac_pkg::STATUS_INVALID;
			return res;
		end
		a = day_serial(r.start_year, r.start_month, r.start_day);
		b = day_serial(r.end_year, r.end_month, r.end_day);
		if (b <= a) begin
			res.status = dac_pkg::STATUS_ORDER;
			return res;
		end
		diff = b - a;
		res.age_months = 14'((diff + 29) / 30);
		res.age_weeks  = 16'((diff + 6) / 7);
		res.age_days   = 19'(diff);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic void pick_date(input int unsigned ylo, input int unsigned yhi,
			output logic [11:0] y, output logic [3:0] m, output logic [5:0] d);
		y = 12'($urandom_range(yhi, ylo));
		m = 4'($urandom_range(12, 1));
		d = 6'($urandom_range(month_days(y, m), 1));
	endfunction

	task automatic queue_dates(input int unsigned sy, input int unsigned sm,
			input int unsigned sd, input int unsigned ey, input int unsigned em,
			input int unsigned ed, input bit drain);
		queued_req_t q;
		q.drain = drain;
		q.payload.start_year  = 12'(sy);
		q.payload.start_month = 4'(sm);
		q.payload.start_day   = 6'(sd);
		q.payload.end_year    = 12'(ey);
		q.payload.end_month   = 4'(em);
		q.payload.end_day     = 6'(ed);
		req_backlog.push_back(q);
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t result %0d: %s", $realtime, results_checked, msg);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// request driver: bursts with random gaps
	// ------------------------------------------------------------------
	always @(posedge clk) begin : sender
		bit fire;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			fire = req_valid && req_ready;
			if (fire)
				expected_rsp.push_back(predict_age(req));
			if (!req_valid || fire) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() > 0 &&
						!(req_backlog[0].drain && expected_rsp.size() > 0)) begin
					if (req_backlog[0].drain)
						drains++;
					req       <= req_backlog[0].payload;
					req_valid <= 1'b1;
					req_backlog.pop_front();
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(4, 0) == 0) ?
							$urandom_range(120, 40) : $urandom_range(12, 1);
						gap_left = ($urandom_range(9, 0) == 0) ?
							$urandom_range(25, 8) : $urandom_range(5, 0);
					end else begin
						burst_left--;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor and receiver stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin : receiver
		dac_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp.status, want.status));
					if (rsp.age_months !== want.age_months)
						report_mismatch($sformatf("age_months %0d, want %0d",
							rsp.age_months, want.age_months));
					if (rsp.age_weeks !== want.age_weeks)
						report_mismatch($sformatf("age_weeks %0d, want %0d",
							rsp.age_weeks, want.age_weeks));
					if (rsp.age_days !== want.age_days)
						report_mismatch($sformatf("age_days %0d, want %0d",
							rsp.age_days, want.age_days));
					case (want.status)
						dac_pkg::STATUS_OK:      ok_count++;
						dac_pkg::STATUS_INVALID: invalid_count++;
						default:                 order_count++;
					endcase
				end
				results_checked++;
			end
			// rotating stall pattern, reshuffled each time pattern_age wraps
			if (pattern_age == 63) begin
				pattern_age = 0;
				case ($urandom_range(3, 0))
					0:       stall_pattern = 16'hffff;
					1:       stall_pattern = 16'($urandom()) | 16'h8421;
					default: stall_pattern = 16'($urandom());
				endcase
			end else begin
				pattern_age++;
				stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
			end
			rsp_ready <= stall_pattern[0];
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_rsp.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [11:0] sy, ey;
		logic [3:0]  sm, em;
		logic [5:0]  sd, ed;
		int unsigned k;
		int unsigned i;

		// directed: calendar edges
		queue_dates(2000, 1, 1, 2000, 1, 2, 0);
		queue_dates(1900, 1, 1, 3000, 12, 31, 0);       // widest span
		queue_dates(1899, 12, 31, 2000, 1, 1, 0);       // start year too low
		queue_dates(1950, 6, 15, 3001, 1, 1, 0);        // end year too high
		queue_dates(0, 0, 0, 4095, 15, 63, 0);          // all fields at their extremes
		queue_dates(4095, 15, 63, 0, 0, 0, 0);
		queue_dates(2010, 0, 10, 2011, 1, 1, 0);        // month zero
		queue_dates(2010, 5, 10, 2011, 13, 1, 0);       // month thirteen
		queue_dates(2010, 1, 0, 2011, 1, 1, 0);         // day zero
		queue_dates(2010, 1, 32, 2011, 1, 1, 0);        // day past month end
		queue_dates(2010, 4, 31, 2011, 1, 1, 0);        // thirty-day month
		queue_dates(1900, 2, 29, 1901, 1, 1, 0);        // century, not leap
		queue_dates(2000, 2, 29, 2001, 1, 1, 0);        // four-hundred, leap
		queue_dates(2004, 2, 29, 2100, 2, 28, 0);
		queue_dates(2004, 1, 1, 2100, 2, 29, 0);        // century, not leap
		queue_dates(2000, 2, 30, 2001, 1, 1, 0);
		queue_dates(2020, 7, 4, 2020, 7, 4, 1);         // equal dates, after a drain
		queue_dates(2021, 7, 4, 2020, 7, 4, 0);         // reversed
		queue_dates(2021, 7, 4, 1899, 7, 4, 0);         // reversed and invalid
		queue_dates(2001, 3, 1, 2001, 3, 31, 0);        // exactly 30 days
		queue_dates(2001, 3, 1, 2001, 4, 1, 0);         // 31 days
		queue_dates(2001, 3, 1, 2001, 3, 8, 0);         // exactly 7 days
		queue_dates(2001, 3, 1, 2001, 3, 9, 0);
		queue_dates(2000, 2, 28, 2000, 3, 1, 0);        // across a leap day
		queue_dates(3000, 12, 30, 3000, 12, 31, 0);

		for (i = 0; i < RANDOM_REQS; i++) begin
			k = $urandom_range(99, 0);
			pick_date(dac_pkg::YEAR_MIN, dac_pkg::YEAR_MAX, sy, sm, sd);
			if (k < 50) begin
				if ($urandom_range(1, 0))
					pick_date(dac_pkg::YEAR_MIN, dac_pkg::YEAR_MAX, ey, em, ed);
				else
					pick_date(sy, (sy + 2 > dac_pkg::YEAR_MAX) ? dac_pkg::YEAR_MAX : sy + 2,
						ey, em, ed);
			end else if (k < 60) begin
				// same month: equal, reversed or short spans
				ey = sy;
				em = sm;
				ed = 6'($urandom_range(month_days(sy, sm), 1));
			end else if (k < 75) begin
				case ($urandom_range(5, 0))
					0:       sy = 12'($urandom_range(1901, 1898));
					1:       sy = 12'($urandom_range(3002, 2999));
					default: ;
				endcase
				pick_date(dac_pkg::YEAR_MIN, dac_pkg::YEAR_MAX, ey, em, ed);
				if ($urandom_range(1, 0))
					ey = 12'($urandom_range(3002, 1898));
				// late February, leap or not
				if ($urandom_range(1, 0)) begin
					sm = 4'd2;
					sd = 6'($urandom_range(30, 28));
				end else begin
					em = 4'd2;
					ed = 6'($urandom_range(30, 28));
				end
			end else if (k < 88) begin
				pick_date(dac_pkg::YEAR_MIN, dac_pkg::YEAR_MAX, ey, em, ed);
				case ($urandom_range(5, 0))
					0:       sy = 12'($urandom());
					1:       sm = 4'($urandom());
					2:       sd = 6'($urandom());
					3:       ey = 12'($urandom());
					4:       em = 4'($urandom());
					default: ed = 6'($urandom());
				endcase
			end else begin
				sy = 12'($urandom());
				sm = 4'($urandom());
				sd = 6'($urandom());
				ey = 12'($urandom());
				em = 4'($urandom());
				ed = 6'($urandom());
			end
			queue_dates(sy, sm, sd, ey, em, ed, (i % 400) == 200);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("checked %0d results: %0d ok, %0d invalid date, %0d end not after start",
			results_checked, ok_count, invalid_count, order_count);
		$display("sender emptied the pipeline %0d times; %0d mismatches",
			drains, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
